/* rtl/sha1bs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sha1bs_pkg;

    // initial chaining value
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LEN_FILL   = 6'd56;

    // source of the byte written into the block
    localparam logic [1:0] SEL_IN   = 2'd0;
    localparam logic [1:0] SEL_MARK = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic       absorb;
        logic [1:0] byte_sel;
        logic       count;
        logic       start;
        logic       round;
        logic       finalise;
        logic       reinit;
        logic [2:0] word_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/sha1_byte_stream_hasher.sv */
// SHA-1 hasher fed one message byte per input word.
// Input channel (in_valid / in_stall / in_data): a word carries an optional
// byte (byte_present) and an optional end-of-message flag. Bytes are taken one
// per cycle while in_stall is low; the 64th byte of a block starts the
// compression, which holds in_stall high through 80 rounds in one shared
// round unit and then the chaining add.
// End of message: the 0x80 marker, zero fill and the 64-bit length are
// written one byte per cycle, followed by one or two compressions, before the
// digest appears.
// Output channel (out_valid / out_stall / out_data): five 32-bit digest words,
// H0 first, last_word set on the fifth. A stalled word holds; no new input is
// taken until the fifth word is taken, then the hash state reinitialises.
// Reset (rst_n low, asynchronous) loads the initial chaining value and clears
// the byte and length counts; the block is then ready for a new message.
`timescale 1ns / 1ps
`default_nettype none

module sha1_byte_stream_hasher (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire sha1bs_pkg::in_word_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sha1bs_pkg::out_word_t      out_data
);
    import sha1bs_pkg::*;

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic [31:0] digest;
    logic        last_word;

    sha1bs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (in_data.byte_present),
        .end_of_message (in_data.end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .last_word      (last_word),
        .cmd            (cmd),
        .sts            (sts)
    );

    sha1bs_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_data.data_byte),
        .cmd     (cmd),
        .sts     (sts),
        .digest  (digest)
    );

    assign out_data.digest_word = digest;
    assign out_data.last_word   = last_word;

endmodule

`default_nettype wire

/* rtl/sha1bs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha1bs_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         in_byte,
    input  wire sha1bs_pkg::dp_cmd_t cmd,
    output sha1bs_pkg::dp_sts_t     sts,
    output logic [31:0]             digest
);
    import sha1bs_pkg::*;

    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [5:0]  fill_reg;
    logic [60:0] msg_reg;
    logic [6:0]  rnd_reg;
    logic [23:0] acc_reg;
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [7:0]  byte_val;
    logic [63:0] bit_len;
    logic [63:0] len_shift;
    logic [31:0] new_word;
    logic [31:0] sched_word;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    // length in bits, big-endian byte picked by position within the last eight
    assign bit_len   = {msg_reg, 3'b000};
    assign len_shift = bit_len >> {~fill_reg[2:0], 3'b000};

    // byte source
    always_comb
    begin
        case (cmd.byte_sel)
            SEL_IN:   byte_val = in_byte;
            SEL_MARK: byte_val = PAD_MARK;
            SEL_ZERO: byte_val = 8'h00;
            SEL_LEN:  byte_val = len_shift[7:0];
            default:  byte_val = 8'h00;
        endcase
    end

    assign new_word   = {acc_reg, byte_val};
    assign sched_word = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    // round function and constant
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];

    // chaining value update
    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.reinit)
        begin
            chain_next[0] = IV0;
            chain_next[1] = IV1;
            chain_next[2] = IV2;
            chain_next[3] = IV3;
            chain_next[4] = IV4;
        end
        else if (cmd.finalise)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
            fill_reg     <= '0;
            msg_reg      <= '0;
            rnd_reg      <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            if (cmd.reinit)
            begin
                fill_reg <= '0;
                msg_reg  <= '0;
            end
            else
            begin
                if (cmd.absorb)
                    fill_reg <= fill_reg + 6'd1;
                if (cmd.count)
                    msg_reg <= msg_reg + 61'd1;
            end
            if (cmd.start)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 7'd1;
        end
    end

    // byte packing, schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            acc_reg <= {acc_reg[15:0], byte_val};
            if (fill_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= new_word;
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= {sched_word[30:0], sched_word[31]};
        end

        if (cmd.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // digest word select
    always_comb
    begin
        case (cmd.word_sel)
            3'd0:    digest = chain_reg[0];
            3'd1:    digest = chain_reg[1];
            3'd2:    digest = chain_reg[2];
            3'd3:    digest = chain_reg[3];
            3'd4:    digest = chain_reg[4];
            default: digest = chain_reg[4];
        endcase
    end

    assign sts.fill       = fill_reg;
    assign sts.round_last = (rnd_reg == LAST_ROUND);

endmodule

`default_nettype wire

/* rtl/sha1bs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha1bs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                byte_present,
    input  wire logic                end_of_message,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     last_word,
    output sha1bs_pkg::dp_cmd_t      cmd,
    input  wire sha1bs_pkg::dp_sts_t sts
);
    import sha1bs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       pad_reg, pad_next;
    logic       len_ok_reg, len_ok_next;
    logic       final_reg, final_next;
    logic [2:0] idx_reg, idx_next;
    logic       in_take;
    logic       out_take;
    logic       block_full;

    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid && !out_stall;
    assign block_full = (sts.fill == LAST_FILL);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign last_word = (idx_reg == LAST_WORD_IDX);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        pad_next     = pad_reg;
        len_ok_next  = len_ok_reg;
        final_next   = final_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.byte_sel = SEL_IN;
        cmd.word_sel = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (byte_present)
                    begin
                        cmd.absorb = 1'b1;
                        cmd.count  = 1'b1;
                    end
                    if (byte_present && block_full)
                    begin
                        cmd.start  = 1'b1;
                        fin_next   = end_of_message;
                        final_next = 1'b0;
                        state_next = S_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_last)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.finalise = 1'b1;
                if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else if (fin_reg)
                begin
                    fin_next   = 1'b0;
                    state_next = S_MARK;
                end
                else if (pad_reg)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_MARK:
            begin
                cmd.absorb   = 1'b1;
                cmd.byte_sel = SEL_MARK;
                pad_next     = 1'b1;
                len_ok_next  = (sts.fill < LEN_FILL);
                // marker in the last slot: the next block carries the length
                if (block_full)
                begin
                    cmd.start   = 1'b1;
                    final_next  = 1'b0;
                    len_ok_next = 1'b1;
                    state_next  = S_ROUND;
                end
                else
                    state_next = S_PAD;
            end
            S_PAD:
            begin
                cmd.absorb   = 1'b1;
                cmd.byte_sel = (len_ok_reg && sts.fill >= LEN_FILL) ? SEL_LEN : SEL_ZERO;
                if (block_full)
                begin
                    cmd.start   = 1'b1;
                    final_next  = len_ok_reg;
                    len_ok_next = 1'b1;
                    state_next  = S_ROUND;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    if (idx_reg == LAST_WORD_IDX)
                    begin
                        cmd.reinit  = 1'b1;
                        pad_next    = 1'b0;
                        final_next  = 1'b0;
                        len_ok_next = 1'b0;
                        idx_next    = '0;
                        state_next  = S_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_reg    <= 1'b0;
            pad_reg    <= 1'b0;
            len_ok_reg <= 1'b0;
            final_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            pad_reg    <= pad_next;
            len_ok_reg <= len_ok_next;
            final_reg  <= final_next;
            idx_reg    <= idx_next;
        end
    end

    // checks
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && last_word |=> state_reg == S_IDLE)
        else $error("digest end did not return to idle");

    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD |-> $past(state_reg) == S_ROUND && $past(sts.round_last))
        else $error("final add without eighty rounds");

    a_out_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> sts.fill == 6'd0)
        else $error("digest shown with partial block");

    a_out_starts_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_OUT) |-> idx_reg == 3'd0)
        else $error("digest does not start at first word");

endmodule

`default_nettype wire
